FILE: design/wlan_info_element_parser_defines.svh
// Assertion macros used by the information-element parser RTL.
`ifndef WLAN_INFO_ELEMENT_PARSER_DEFINES_SVH
`define WLAN_INFO_ELEMENT_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define WIEP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define WIEP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/wiep_pkg.sv
// Types, constants and helper functions of the information-element parser.
package wiep_pkg;

	localparam int SSID_MAX = 32;
	localparam int SSID_IDX_W = $clog2(SSID_MAX);
	localparam int SSID_LEN_W = SSID_IDX_W + 1;

	localparam logic [7:0] ID_SSID   = 8'd0;
	localparam logic [7:0] ID_RSN    = 8'd48;
	localparam logic [7:0] ID_VENDOR = 8'd221;
	localparam logic [7:0] WPA_MIN_LEN = 8'd4;

	localparam logic [1:0] SEC_OPEN = 2'd0;
	localparam logic [1:0] SEC_WPA  = 2'd1;
	localparam logic [1:0] SEC_RSN  = 2'd2;

	typedef enum logic [1:0] {
		PH_ID   = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef logic [7:0] byte_t;

	// Expected leading bytes of a WPA vendor element: 00 50 F2 01.
	function automatic byte_t wpa_prefix(input logic [1:0] idx);
		byte_t val;
		case (idx)
			2'd0: val = 8'h00;
			2'd1: val = 8'h50;
			2'd2: val = 8'hF2;
			2'd3: val = 8'h01;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

FILE: design/wiep_if.sv
// Valid/ready channel interfaces for the parser input bytes and results.
interface wiep_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ie_byte;
	logic       last_byte;

	modport source (output valid, output ie_byte, output last_byte, input ready);
	modport sink (input valid, input ie_byte, input last_byte, output ready);
endinterface

interface wiep_out_if;
	import wiep_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            security;
	logic                  is_open;
	logic [SSID_LEN_W-1:0] ssid_size;
	logic [7:0]            ssid_byte;
	logic [SSID_IDX_W-1:0] byte_index;
	logic                  last;

	modport source (output valid, output security, output is_open, output ssid_size,
		output ssid_byte, output byte_index, output last, input ready);
	modport sink (input valid, input security, input is_open, input ssid_size,
		input ssid_byte, input byte_index, input last, output ready);
endinterface

FILE: design/wlan_info_element_parser.sv
// Top level of the 802.11 information-element parser.
//
// Usage: the ie channel carries the information-element bytes of one beacon
// or probe response, one byte per transaction, with last_byte set on the final
// byte of the blob. The block walks the id, length and body records as the
// bytes arrive and keeps the last complete SSID element of at most 32 bytes,
// an RSN flag and a WPA vendor-element flag. Records cut short by the final
// byte have no effect.
//
// A byte is taken every cycle, except that the final byte of a blob can wait
// as told below. The transaction with last_byte set snapshots the result
// into an output buffer, and the first result transaction is offered on res in
// the next cycle. The blob yields one result per SSID byte (one result when the
// SSID is empty), one per cycle while res is ready. Bytes of the next blob keep
// flowing while these results go out; only its final byte waits while the
// previous blob's results are still being delivered.
//
// Reset: arst_n clears the parser to expect an element id and empties the
// output. The SSID byte arrays are not reset; only written entries are read.
// When the receiver stalls, res holds its transaction unchanged.
module wlan_info_element_parser (
	input logic       clk,
	input logic       arst_n,
	wiep_in_if.sink   ie,
	wiep_out_if.source res
);
	import wiep_pkg::*;

	`include "wlan_info_element_parser_defines.svh"

	// Parser state for the blob being received.
	phase_t                phase_q;
	logic [7:0]            elem_id_q;
	logic [7:0]            elem_len_q;
	logic [7:0]            body_pos_q;
	logic [SSID_LEN_W-1:0] kept_len_q;
	logic                  rsn_q;
	logic                  wpa_q;
	logic                  oui_q;

	// Bytes of the SSID element in flight, and of the SSID kept so far.
	byte_t ssid_stage_q [SSID_MAX];
	byte_t ssid_store_q [SSID_MAX];

	// Output buffer: a snapshot of the finished blob being delivered.
	byte_t                 out_buf_q [SSID_MAX];
	logic                  out_busy_q;
	logic [SSID_IDX_W-1:0] out_idx_q;
	logic [SSID_LEN_W-1:0] out_len_q;
	logic [1:0]            out_sec_q;

	logic                  in_fire;
	logic                  out_fire;
	logic                  out_last;
	logic                  in_body;
	logic                  fin_el;
	logic [7:0]            eff_len;
	logic                  oui_next;
	logic                  stage_wr;
	logic                  ssid_take;
	logic [SSID_LEN_W-1:0] kept_next;
	logic                  rsn_next;
	logic                  wpa_next;
	phase_t                phase_next;
	logic [7:0]            body_pos_next;
	byte_t                 stage_view [SSID_MAX];
	byte_t                 store_next [SSID_MAX];
	logic [1:0]            sec_next;

	// Output side. The last result of a blob also frees the buffer, so a
	// final byte may be taken in the same cycle.
	assign out_last = (out_len_q == '0) ||
		({1'b0, out_idx_q} == out_len_q - SSID_LEN_W'(1));
	assign out_fire = res.valid && res.ready;

	assign ie.ready = !ie.last_byte || !out_busy_q || (res.ready && out_last);
	assign in_fire  = ie.valid && ie.ready;

	assign res.valid      = out_busy_q;
	assign res.security   = out_sec_q;
	assign res.is_open    = (out_sec_q == SEC_OPEN);
	assign res.ssid_size  = out_len_q;
	assign res.ssid_byte  = (out_len_q == '0) ? 8'h00 : out_buf_q[out_idx_q];
	assign res.byte_index = out_idx_q;
	assign res.last       = out_last;

	// Per-byte decode of the current record.
	always_comb begin
		in_body  = (phase_q == PH_BODY);
		eff_len  = (phase_q == PH_LEN) ? ie.ie_byte : elem_len_q;
		fin_el   = ((phase_q == PH_LEN) && (ie.ie_byte == 8'd0)) ||
			(in_body && ({1'b0, body_pos_q} + 9'd1 >= {1'b0, elem_len_q}));

		// The vendor prefix check starts fresh with every element body.
		oui_next = (phase_q == PH_LEN) ? 1'b1 : oui_q;
		if (in_body && (elem_id_q == ID_VENDOR) && (body_pos_q[7:2] == 6'd0) &&
			(ie.ie_byte != wpa_prefix(body_pos_q[1:0]))) begin
			oui_next = 1'b0;
		end

		stage_wr  = in_body && (elem_id_q == ID_SSID) &&
			(body_pos_q < 8'(SSID_MAX));
		ssid_take = fin_el && (elem_id_q == ID_SSID) && (eff_len <= 8'(SSID_MAX));
		kept_next = ssid_take ? eff_len[SSID_LEN_W-1:0] : kept_len_q;
		rsn_next  = rsn_q || (fin_el && (elem_id_q == ID_RSN));
		wpa_next  = wpa_q || (fin_el && (elem_id_q == ID_VENDOR) &&
			(eff_len >= WPA_MIN_LEN) && oui_next);

		// The byte that completes an SSID element lands in the copy as well.
		for (int i = 0; i < SSID_MAX; i++) begin
			stage_view[i] = (stage_wr && (body_pos_q[SSID_IDX_W-1:0] == SSID_IDX_W'(i))) ?
				ie.ie_byte : ssid_stage_q[i];
			store_next[i] = ssid_take ? stage_view[i] : ssid_store_q[i];
		end

		sec_next = rsn_next ? SEC_RSN : (wpa_next ? SEC_WPA : SEC_OPEN);
	end

	// Next phase and body position.
	always_comb begin
		phase_next    = phase_q;
		body_pos_next = body_pos_q;
		case (phase_q)
			PH_ID: begin
				phase_next = PH_LEN;
			end
			PH_LEN: begin
				body_pos_next = 8'd0;
				phase_next    = fin_el ? PH_ID : PH_BODY;
			end
			PH_BODY: begin
				if (fin_el) begin
					phase_next    = PH_ID;
					body_pos_next = 8'd0;
				end else begin
					body_pos_next = body_pos_q + 8'd1;
				end
			end
			default: begin
				phase_next    = PH_ID;
				body_pos_next = 8'd0;
			end
		endcase
	end

	// Parser registers. The final byte of a blob clears them for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ID;
			elem_id_q  <= 8'd0;
			elem_len_q <= 8'd0;
			body_pos_q <= 8'd0;
			kept_len_q <= '0;
			rsn_q      <= 1'b0;
			wpa_q      <= 1'b0;
			oui_q      <= 1'b1;
		end else if (in_fire) begin
			if (ie.last_byte) begin
				phase_q    <= PH_ID;
				elem_id_q  <= 8'd0;
				elem_len_q <= 8'd0;
				body_pos_q <= 8'd0;
				kept_len_q <= '0;
				rsn_q      <= 1'b0;
				wpa_q      <= 1'b0;
				oui_q      <= 1'b1;
			end else begin
				phase_q    <= phase_next;
				if (phase_q == PH_ID) begin
					elem_id_q <= ie.ie_byte;
				end
				if (phase_q == PH_LEN) begin
					elem_len_q <= ie.ie_byte;
				end
				body_pos_q <= body_pos_next;
				kept_len_q <= kept_next;
				rsn_q      <= rsn_next;
				wpa_q      <= wpa_next;
				oui_q      <= fin_el ? 1'b1 : oui_next;
			end
		end
	end

	// SSID byte arrays and the output buffer hold payload only.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < SSID_MAX; i++) begin
				ssid_stage_q[i] <= stage_view[i];
				ssid_store_q[i] <= store_next[i];
			end
			if (ie.last_byte) begin
				for (int i = 0; i < SSID_MAX; i++) begin
					out_buf_q[i] <= store_next[i];
				end
			end
		end
	end

	// Output sequencer: walks the buffered SSID one byte per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
			out_len_q  <= '0;
			out_sec_q  <= SEC_OPEN;
		end else begin
			if (in_fire && ie.last_byte) begin
				out_busy_q <= 1'b1;
				out_idx_q  <= '0;
				out_len_q  <= kept_next;
				out_sec_q  <= sec_next;
			end else if (out_fire) begin
				if (out_last) begin
					out_busy_q <= 1'b0;
				end else begin
					out_idx_q <= out_idx_q + SSID_IDX_W'(1);
				end
			end
		end
	end

	// A blob's results run without a gap until the one marked last.
	`WIEP_ASSERT_NEXT(a_no_gap, res.valid && res.ready && !res.last, res.valid,
		"result sequence ended before its last transaction")
	// The index never runs past the kept SSID length.
	`WIEP_ASSERT_NOW(a_idx_range, res.valid,
		(res.ssid_size == '0 && res.byte_index == '0) ||
		({1'b0, res.byte_index} < res.ssid_size),
		"byte index outside the kept SSID")
	// The final byte of a blob always produces results in the next cycle.
	`WIEP_ASSERT_NEXT(a_blob_out, ie.valid && ie.ready && ie.last_byte, res.valid,
		"final byte taken without results")
	// Security class and open flag agree.
	`WIEP_ASSERT_NOW(a_open_flag, res.valid,
		res.is_open == (res.security == SEC_OPEN),
		"open flag disagrees with security class")

endmodule

FILE: dv/wlan_info_element_parser_tb.sv
// Testbench for the information-element parser: random beacon blobs checked against a predictor.
module wlan_info_element_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wiep_pkg::*;

	// One input transaction: a blob byte and the flag that closes the blob.
	typedef struct packed {
		byte_t ie_byte;
		logic  last_byte;
	} ie_item_t;

	// One result transaction as the block should present it.
	typedef struct packed {
		logic [1:0]            security;
		logic                  is_open;
		logic [SSID_LEN_W-1:0] ssid_size;
		byte_t                 ssid_byte;
		logic [SSID_IDX_W-1:0] byte_index;
		logic                  last;
	} scan_report_t;

	// Leading body bytes of a WPA vendor element (OUI 00-50-F2, type 1).
	localparam byte_t WPA_OUI_TYPE [4] = '{8'h00, 8'h50, 8'hF2, 8'h01};

	// The receiver is held off this long, twice, to back the block up into its input.
	localparam int HOLD_CYCLES = 300;
	// Cycles without any transaction before the run is declared hung. The longest
	// legal quiet stretch is the hold above plus a short receiver stall.
	localparam int HANG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_BYTES = 460;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Driven registers, all known from time zero.
	logic  drv_valid = 1'b0;
	byte_t drv_byte = 8'h00;
	logic  drv_last = 1'b0;
	logic  rcv_ready = 1'b0;

	wiep_in_if  ie_ch ();
	wiep_out_if res_ch ();

	assign ie_ch.valid     = drv_valid;
	assign ie_ch.ie_byte   = drv_byte;
	assign ie_ch.last_byte = drv_last;
	assign res_ch.ready    = rcv_ready;

	wlan_info_element_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.ie     (ie_ch),
		.res    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor state: a shadow of the parser, advanced one byte at a time as
	// each input transaction is accepted.
	// ---------------------------------------------------------------------
	phase_t                ie_phase = PH_ID;
	byte_t                 cur_id = 8'h00;
	byte_t                 cur_len = 8'h00;
	byte_t                 body_idx = 8'h00;
	byte_t                 ssid_staged [SSID_MAX];
	byte_t                 ssid_kept [SSID_MAX];
	logic [SSID_LEN_W-1:0] kept_len = '0;
	logic                  rsn_found = 1'b0;
	logic                  wpa_found = 1'b0;
	logic                  oui_ok = 1'b1;

	ie_item_t     ie_pending [$];   // bytes still to be offered, oldest first
	scan_report_t scan_reports [$]; // results the block still owes, oldest first
	byte_t        blob [$];         // blob under construction by the stimulus

	int fail_count = 0;
	int reports_seen = 0;

	// An element whose body has fully arrived takes effect here. Only complete
	// records reach this point, so a record cut short by the last byte is lost.
	task automatic close_element();
		if (cur_id == ID_SSID && cur_len <= SSID_MAX) begin
			// Long SSID elements fall through and leave the kept SSID alone.
			for (int i = 0; i < int'(cur_len); i++)
				ssid_kept[i] = ssid_staged[i];
			kept_len = cur_len[SSID_LEN_W-1:0];
		end
		if (cur_id == ID_RSN)
			rsn_found = 1'b1;
		if (cur_id == ID_VENDOR && cur_len >= WPA_MIN_LEN && oui_ok)
			wpa_found = 1'b1;
		ie_phase = PH_ID;
		body_idx = 8'h00;
		oui_ok = 1'b1;
	endtask

	// Walk one byte of the id/length/body record stream. On the closing byte
	// the blob's report is queued, one result per kept SSID byte.
	task automatic parse_ie_byte(input byte_t b, input logic fin);
		int           n;
		scan_report_t rpt;
		case (ie_phase)
			PH_ID: begin
				cur_id = b;
				ie_phase = PH_LEN;
			end
			PH_LEN: begin
				cur_len = b;
				body_idx = 8'h00;
				oui_ok = 1'b1;
				if (b == 8'h00)
					close_element();
				else
					ie_phase = PH_BODY;
			end
			default: begin
				if (cur_id == ID_SSID && body_idx < SSID_MAX)
					ssid_staged[body_idx[SSID_IDX_W-1:0]] = b;
				if (cur_id == ID_VENDOR && body_idx < 4 && b != WPA_OUI_TYPE[body_idx[1:0]])
					oui_ok = 1'b0;
				if (int'(body_idx) + 1 >= int'(cur_len))
					close_element();
				else
					body_idx = body_idx + 8'd1;
			end
		endcase
		if (fin) begin
			// An empty or hidden SSID still yields a single result.
			n = (kept_len == 0) ? 1 : int'(kept_len);
			for (int k = 0; k < n; k++) begin
				rpt.security = rsn_found ? SEC_RSN : (wpa_found ? SEC_WPA : SEC_OPEN);
				rpt.is_open = (rpt.security == SEC_OPEN);
				rpt.ssid_size = kept_len;
				rpt.ssid_byte = (kept_len == 0) ? 8'h00 : ssid_kept[k[SSID_IDX_W-1:0]];
				rpt.byte_index = k[SSID_IDX_W-1:0];
				rpt.last = (k == n - 1);
				scan_reports.push_back(rpt);
			end
			// Per-blob state starts over; the SSID arrays keep their contents.
			ie_phase = PH_ID;
			cur_id = 8'h00;
			cur_len = 8'h00;
			body_idx = 8'h00;
			kept_len = '0;
			rsn_found = 1'b0;
			wpa_found = 1'b0;
			oui_ok = 1'b1;
		end
	endtask

	function automatic string report_str(input scan_report_t r);
		return $sformatf("sec=%0d open=%0b len=%0d byte=%02h idx=%0d last=%0b",
			r.security, r.is_open, r.ssid_size, r.ssid_byte, r.byte_index, r.last);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Compare an accepted result transaction with the oldest outstanding one.
	task automatic check_report();
		scan_report_t got;
		scan_report_t want;
		got.security = res_ch.security;
		got.is_open = res_ch.is_open;
		got.ssid_size = res_ch.ssid_size;
		got.ssid_byte = res_ch.ssid_byte;
		got.byte_index = res_ch.byte_index;
		got.last = res_ch.last;
		if (scan_reports.size() == 0) begin
			note_failure({"result with none outstanding: ", report_str(got)});
		end else begin
			want = scan_reports.pop_front();
			if (got.security !== want.security || got.is_open !== want.is_open ||
				got.ssid_size !== want.ssid_size || got.ssid_byte !== want.ssid_byte ||
				got.byte_index !== want.byte_index || got.last !== want.last) begin
				note_failure({"expected ", report_str(want), " got ", report_str(got)});
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Stimulus construction. Elements are appended to the blob under
	// construction; ship_blob() moves it to the pending queue with the closing
	// flag on its final byte, optionally chopping bytes off the end first so
	// that the trailing record is truncated.
	// ---------------------------------------------------------------------

	// Body style: 0 random, 1 exact WPA prefix, 2 WPA prefix with one byte wrong.
	task automatic add_element(input byte_t id, input int len, input int style);
		int    bad;
		byte_t flip;
		bad = $urandom_range(0, (len < 4) ? ((len > 0) ? len - 1 : 0) : 3);
		flip = byte_t'($urandom_range(1, 255));
		blob.push_back(id);
		blob.push_back(byte_t'(len));
		for (int k = 0; k < len; k++) begin
			if (style != 0 && k < 4)
				blob.push_back(WPA_OUI_TYPE[k] ^ ((style == 2 && k == bad) ? flip : 8'h00));
			else
				blob.push_back(byte_t'($urandom_range(0, 255)));
		end
	endtask

	task automatic ship_blob(input int drop);
		ie_item_t item;
		while (drop > 0 && blob.size() > 1) begin
			void'(blob.pop_back());
			drop--;
		end
		if (blob.size() == 0)
			blob.push_back(byte_t'($urandom_range(0, 255)));
		foreach (blob[i]) begin
			item.ie_byte = blob[i];
			item.last_byte = (i == blob.size() - 1);
			ie_pending.push_back(item);
		end
		blob.delete();
	endtask

	// Mostly well-formed elements of the kinds the parser reacts to, with a
	// sprinkling of arbitrary ids and an occasional very long record.
	task automatic add_random_element();
		int r;
		int len;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2: begin
				len = $urandom_range(0, 9);
				if (len < 6)
					len = $urandom_range(0, 8);
				else if (len < 8)
					len = $urandom_range(9, SSID_MAX);
				else if (len == 8)
					len = SSID_MAX;
				else
					len = $urandom_range(SSID_MAX + 1, SSID_MAX + 8);
				add_element(ID_SSID, len, 0);
			end
			3: add_element(ID_RSN, $urandom_range(0, 6), 0);
			4, 5: add_element(ID_VENDOR, $urandom_range(4, 8), ($urandom_range(0, 3) == 0) ? 2 : 1);
			6: add_element(ID_VENDOR, $urandom_range(0, 3), 1);
			7: add_element(byte_t'($urandom_range(0, 255)), $urandom_range(0, 5), 0);
			8: add_element(ID_VENDOR, $urandom_range(4, 6), 0);
			default: begin
				if ($urandom_range(0, 5) == 0)
					add_element(byte_t'($urandom_range(0, 255)), $urandom_range(100, 255), 0);
				else
					add_element(byte_t'($urandom_range(1, 47)), $urandom_range(0, 3), 0);
			end
		endcase
	endtask

	initial begin
		int n_elem;
		int drop;

		// Directed blobs first.
		// A blob of one byte: the record is cut short at its id.
		blob = '{8'hFF};
		ship_blob(0);
		// SSID "abc" plus a proper WPA vendor element.
		blob = '{ID_SSID, 8'd3, 8'h61, 8'h62, 8'h63,
			ID_VENDOR, 8'd4, 8'h00, 8'h50, 8'hF2, 8'h01};
		ship_blob(0);
		// SSID "hi" then an RSN element truncated inside its body: still open.
		blob = '{ID_SSID, 8'd2, 8'h68, 8'h69, ID_RSN, 8'd5, 8'h01};
		ship_blob(0);
		// A later hidden SSID replaces an earlier one; RSN wins over WPA.
		blob = '{ID_SSID, 8'd1, 8'h5A, ID_SSID, 8'd0, ID_RSN, 8'd0,
			ID_VENDOR, 8'd4, 8'h00, 8'h50, 8'hF2, 8'h01};
		ship_blob(0);

		// Random blobs: mostly element sequences, some pure noise, and some
		// with the tail chopped off.
		while (ie_pending.size() < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				n_elem = $urandom_range(1, 12);
				repeat (n_elem)
					blob.push_back(byte_t'($urandom_range(0, 255)));
			end else begin
				n_elem = $urandom_range(0, 5);
				repeat (n_elem)
					add_random_element();
			end
			drop = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
			ship_blob(drop);
		end

		// Reset is asserted from time zero and released on a falling edge, away
		// from the rising edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (ie_pending.size() != 0 || scan_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && scan_reports.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Byte driver. The sender offers bytes in bursts of random length with
	// random gaps between them. A byte on offer is never withdrawn: the next
	// decision is only taken once the current transaction completes or while
	// nothing is offered. Each accepted transaction advances the predictor.
	// ---------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && ie_ch.ready) begin
				parse_ie_byte(ie_pending[0].ie_byte, ie_pending[0].last_byte);
				void'(ie_pending.pop_front());
				if (burst_left > 0)
					burst_left--;
			end
			if (!drv_valid || ie_ch.ready) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (gap_left > 0) begin
					gap_left--;
					drv_valid <= 1'b0;
				end else if (ie_pending.size() != 0) begin
					drv_valid <= 1'b1;
					drv_byte <= ie_pending[0].ie_byte;
					drv_last <= ie_pending[0].last_byte;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result monitor and receiver. Every accepted result transaction is
	// checked. The ready pattern switches between always ready, a coin toss
	// per cycle and mostly stalled. Twice during the run the receiver holds
	// off for a long stretch while the sender keeps offering bytes, so the
	// block's output buffer stays full and the next closing byte backs up.
	// ---------------------------------------------------------------------
	int ready_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	logic ready_next;

	always @(posedge clk) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (res_ch.valid && rcv_ready) begin
				check_report();
				reports_seen++;
				if (reports_seen == 20 || reports_seen == 150)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 48);
				end
				mode_left--;
				case (ready_mode)
					0: ready_next = 1'b1;
					1: ready_next = ($urandom_range(0, 1) == 1);
					default: ready_next = ($urandom_range(0, 3) == 0);
				endcase
			end
			rcv_ready <= ready_next;
		end
	end

	// Watchdog: a run in which neither channel moves for too long is hung.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((drv_valid && ie_ch.ready) || (res_ch.valid && rcv_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("[%0t] no transaction for %0d cycles", $realtime, HANG_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule

FILE: filelist.f
+incdir+design
design/wiep_pkg.sv
design/wiep_if.sv
design/wlan_info_element_parser.sv
dv/wlan_info_element_parser_tb.sv
